// ===== rtl/jac3d_pkg.sv =====
// ============================================================================
// Jacobi 3D sweep package
// Shared constants, payload structs and controller/datapath signal groups.
// ============================================================================
package jac3d_pkg;

    localparam int MAX_EDGE_DEF = 16;

    localparam int SIZE_W  = 5;
    localparam int H2_W    = 32;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 12;
    localparam int ACT_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Arithmetic widths of the sweep.
    localparam int SUM_W     = 38;
    localparam int DIV_W     = 36;
    localparam int DIV_DIGITS = 6;

    localparam logic [ACT_W-1:0] ACT_LOAD_RHS = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_SOL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SWEEP    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_I  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_J  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_K  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SQ = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [IDX_W-1:0]        point_index;
        logic signed [VAL_W-1:0] sample_value;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic                    index_error;
    } result_t;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic exec_op;
        logic issue;
        logic sum_go;
        logic div_start;
        logic write_pt;
        logic result_go;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic fetch_last;
        logic point_last;
        logic div_done;
    } dp_stat_t;

endpackage

// ===== rtl/jac3d_div6.sv =====
// ============================================================================
// Divide by six
// Restoring division by the constant six, several quotient bits per cycle.
// ============================================================================
module jac3d_div6
    import jac3d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_W-1:0]   dividend,
    output logic               done,
    output logic [VAL_W-1:0]   quotient
);

    localparam int STEPS = DIV_W / DIV_DIGITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [2:0]       rem_reg;
    logic [DIV_W-1:0] num_reg;
    logic [DIV_W-1:0] quo_reg;

    logic [2:0]       rem_next;
    logic [DIV_W-1:0] quo_next;
    logic [3:0]       trial;

    // Each step shifts one dividend bit into the remainder and subtracts six
    // when it fits.
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int b = 0; b < DIV_DIGITS; b++)
        begin
            trial = {rem_next, num_reg[DIV_W-1-b]};
            if (trial >= 4'd6)
            begin
                rem_next = 3'(trial - 4'd6);
                quo_next = {quo_next[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[2:0];
                quo_next = {quo_next[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= num_reg << DIV_DIGITS;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[VAL_W-1:0];

endmodule

// ===== rtl/jac3d_ctrl.sv =====
// ============================================================================
// Jacobi 3D sweep controller
// Sequences the clearing pass, single-point items and the per-point sweep.
// ============================================================================
module jac3d_ctrl
    import jac3d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     sweep_req,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     done
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_OP,
        S_FIN,
        S_FETCH,
        S_DRAIN,
        S_SUM,
        S_DIVGO,
        S_DIVW,
        S_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = sweep_req ? S_FETCH : S_OP;
                end
            end
            S_OP:
            begin
                cmd.exec_op = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                cmd.result_go = 1'b1;
                state_next    = S_IDLE;
            end
            S_FETCH:
            begin
                cmd.issue = 1'b1;
                if (stat.fetch_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_go = 1'b1;
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write_pt = 1'b1;
                state_next   = stat.point_last ? S_FIN : S_FETCH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FIN);
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ===== rtl/jac3d_dp.sv =====
// ============================================================================
// Jacobi 3D sweep datapath
// Configuration, grid memories, point counters, stencil sum and result.
// ============================================================================
module jac3d_dp
    import jac3d_pkg::*;
#(
    parameter int MAX_EDGE = MAX_EDGE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  item_t                item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [H2_W-1:0]      cfg_data,
    output result_t              result
);

    localparam int DEPTH     = MAX_EDGE * MAX_EDGE * MAX_EDGE;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int SA_W      = ADDR_W + 1;
    localparam int SOL_DEPTH = 2 * (1 << ADDR_W);
    localparam int EW        = $clog2(MAX_EDGE + 1);
    localparam int TOT_W     = 3 * EW;

    localparam logic [2:0] NB_I_LO = 3'd0;
    localparam logic [2:0] NB_I_HI = 3'd1;
    localparam logic [2:0] NB_J_LO = 3'd2;
    localparam logic [2:0] NB_J_HI = 3'd3;
    localparam logic [2:0] NB_K_LO = 3'd4;
    localparam logic [2:0] NB_K_HI = 3'd5;

    localparam logic [SUM_W-1:0] SAT_LIM = SUM_W'(64'd6 << 31);

    // Configuration registers.
    logic [SIZE_W-1:0] size_i_reg, size_j_reg, size_k_reg;
    logic [H2_W-1:0]   h2_reg;

    // Memories.
    logic [VAL_W-1:0] sol_mem [SOL_DEPTH];
    logic [VAL_W-1:0] rhs_mem [DEPTH];
    logic signed [VAL_W-1:0] sol_rd_reg;
    logic signed [VAL_W-1:0] rhs_rd_reg;

    // Control and payload registers.
    logic [SA_W-1:0]   clr_reg;
    logic              active_reg;
    item_t             item_reg;
    logic              err_reg;
    logic [EW-1:0]     i_reg, j_reg, k_reg;
    logic [ADDR_W-1:0] pt_reg;
    logic [2:0]        nbr_reg;
    logic              issue_d_reg;
    logic              nvalid_d_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic signed [63:0]      prod_reg;
    logic signed [SUM_W-1:0] sum_reg;
    result_t           result_reg;

    logic [EW-1:0]     ni, nj, nk;
    logic [EW-1:0]     i_last, j_last, k_last;
    logic [2*EW-1:0]   plane;
    logic [TOT_W-1:0]  total;
    logic              idx_err;
    logic [ADDR_W-1:0] idx_addr;
    logic [ADDR_W-1:0] nbr_addr;
    logic              nbr_valid;
    logic [SA_W-1:0]   sol_raddr;
    logic [SUM_W-1:0]  mag;
    logic [DIV_W-1:0]  dividend;
    logic              div_done;
    logic [VAL_W-1:0]  quotient;
    logic [VAL_W-1:0]  new_value;

    function automatic logic [EW-1:0] clamp_edge(input logic [SIZE_W-1:0] v);
        logic [EW-1:0] e;
        if (v == '0)
        begin
            e = EW'(1);
        end
        else if (32'(v) > 32'(MAX_EDGE))
        begin
            e = EW'(MAX_EDGE);
        end
        else
        begin
            e = EW'(v);
        end
        return e;
    endfunction

    assign ni     = clamp_edge(size_i_reg);
    assign nj     = clamp_edge(size_j_reg);
    assign nk     = clamp_edge(size_k_reg);
    assign i_last = ni - 1'b1;
    assign j_last = nj - 1'b1;
    assign k_last = nk - 1'b1;
    assign plane  = (2*EW)'(ni) * (2*EW)'(nj);
    assign total  = TOT_W'(plane) * TOT_W'(nk);

    assign idx_err  = 32'(item_reg.point_index) >= 32'(total);
    assign idx_addr = ADDR_W'(32'(item_reg.point_index));

    // Neighbor address and ghost-layer mask for the current fetch slot.
    always_comb
    begin
        nbr_addr  = pt_reg;
        nbr_valid = 1'b0;
        case (nbr_reg)
            NB_I_LO:
            begin
                nbr_addr  = pt_reg - 1'b1;
                nbr_valid = (i_reg != '0);
            end
            NB_I_HI:
            begin
                nbr_addr  = pt_reg + 1'b1;
                nbr_valid = (i_reg != i_last);
            end
            NB_J_LO:
            begin
                nbr_addr  = pt_reg - ADDR_W'(ni);
                nbr_valid = (j_reg != '0);
            end
            NB_J_HI:
            begin
                nbr_addr  = pt_reg + ADDR_W'(ni);
                nbr_valid = (j_reg != j_last);
            end
            NB_K_LO:
            begin
                nbr_addr  = pt_reg - ADDR_W'(plane);
                nbr_valid = (k_reg != '0);
            end
            NB_K_HI:
            begin
                nbr_addr  = pt_reg + ADDR_W'(plane);
                nbr_valid = (k_reg != k_last);
            end
            default:
            begin
                nbr_addr  = pt_reg;
                nbr_valid = 1'b0;
            end
        endcase
    end

    assign sol_raddr = cmd.issue ? {active_reg, nbr_addr} : {active_reg, idx_addr};

    // Rounding to nearest with halves away from zero: divide |s| + 3 by six.
    // Magnitudes at or above six times 2^31 all saturate, so they are clamped.
    always_comb
    begin
        mag = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(4)) : (sum_reg + SUM_W'(3));
        if (mag >= SAT_LIM)
        begin
            mag = SAT_LIM;
        end
        dividend = DIV_W'(mag);
    end

    always_comb
    begin
        if (sum_reg[SUM_W-1])
        begin
            new_value = ~quotient + 1'b1;
        end
        else if (quotient[VAL_W-1])
        begin
            new_value = {1'b0, {(VAL_W-1){1'b1}}};
        end
        else
        begin
            new_value = quotient;
        end
    end

    jac3d_div6 u_div6 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .done     (div_done),
        .quotient (quotient)
    );

    // Memories.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            sol_mem[clr_reg] <= '0;
        end
        else if (cmd.exec_op && !idx_err && item_reg.action == ACT_LOAD_SOL)
        begin
            sol_mem[{active_reg, idx_addr}] <= item_reg.sample_value;
        end
        else if (cmd.write_pt)
        begin
            sol_mem[{~active_reg, pt_reg}] <= new_value;
        end
        sol_rd_reg <= sol_mem[sol_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_op && !idx_err && item_reg.action == ACT_LOAD_RHS)
        begin
            rhs_mem[idx_addr] <= item_reg.sample_value;
        end
        rhs_rd_reg <= rhs_mem[pt_reg];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_i_reg   <= SIZE_W'(16);
            size_j_reg   <= SIZE_W'(16);
            size_k_reg   <= SIZE_W'(16);
            h2_reg       <= H2_W'(15);
            clr_reg      <= '0;
            active_reg   <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            pt_reg       <= '0;
            nbr_reg      <= '0;
            issue_d_reg  <= 1'b0;
            err_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SIZE_I:  size_i_reg <= cfg_data[SIZE_W-1:0];
                    CFG_SIZE_J:  size_j_reg <= cfg_data[SIZE_W-1:0];
                    CFG_SIZE_K:  size_k_reg <= cfg_data[SIZE_W-1:0];
                    CFG_STEP_SQ: h2_reg     <= cfg_data;
                    default:     h2_reg     <= h2_reg;
                endcase
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            issue_d_reg <= cmd.issue;
            if (cmd.accept)
            begin
                i_reg   <= '0;
                j_reg   <= '0;
                k_reg   <= '0;
                pt_reg  <= '0;
                nbr_reg <= '0;
                err_reg <= 1'b0;
            end
            if (cmd.exec_op)
            begin
                err_reg <= idx_err;
            end
            if (cmd.issue)
            begin
                nbr_reg <= (nbr_reg == NB_K_HI) ? NB_I_LO : nbr_reg + 1'b1;
            end
            if (cmd.write_pt)
            begin
                pt_reg <= pt_reg + 1'b1;
                if (i_reg == i_last)
                begin
                    i_reg <= '0;
                    if (j_reg == j_last)
                    begin
                        j_reg <= '0;
                        k_reg <= k_reg + 1'b1;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                end
                if (stat.point_last)
                begin
                    active_reg <= ~active_reg;
                end
            end
        end
    end

    // Stencil arithmetic.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
        end
        nvalid_d_reg <= nbr_valid;
        prod_reg     <= $signed({1'b0, h2_reg}) * rhs_rd_reg;
        if (cmd.issue && nbr_reg == NB_I_LO)
        begin
            acc_reg <= '0;
        end
        else if (issue_d_reg && nvalid_d_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(sol_rd_reg);
        end
        if (cmd.sum_go)
        begin
            sum_reg <= acc_reg + SUM_W'($signed(prod_reg[63:28]));
        end
        if (cmd.result_go)
        begin
            result_reg.index_error <= err_reg;
            result_reg.read_value  <= (item_reg.action == ACT_READ && !err_reg)
                                      ? sol_rd_reg : '0;
        end
    end

    assign stat.clear_last = &clr_reg;
    assign stat.fetch_last = (nbr_reg == NB_K_HI);
    assign stat.point_last = (i_reg == i_last) && (j_reg == j_last) && (k_reg == k_last);
    assign stat.div_done   = div_done;
    assign result          = result_reg;

endmodule

// ===== rtl/jacobi_3d_seven_point_sweep.sv =====
// ============================================================================
// Jacobi 3D seven-point sweep
// Grid store with load, read-back and one-sweep Jacobi relaxation items.
// ============================================================================
// An item is transferred at a rising edge with start high and busy low; busy
// then stays high until its result has been produced. Every item gives one
// result, shown on result for exactly one cycle while done is high. The
// receiver cannot stall, so done is never held and nothing waits on it.
// Loads and reads pass the memory access into the registered read data and
// then the result register; done rises together with the result register.
// Busy falls as done rises, so the next item can be transferred at the edge
// that ends the done cycle.
// A sweep visits the points in linear order. For each point it makes six
// neighbor reads through the single read port of the solution memory, then
// a drain, a sum, a divide start, the divide-by-six unit that retires six
// quotient bits a cycle, and one write.
// After reset the block clears both solution banks with one write a cycle
// and holds busy high meanwhile. The configuration channel is always ready
// and its transfers are taken at any time; change the registers only while
// the block is idle.
// ============================================================================
module jacobi_3d_seven_point_sweep
    import jac3d_pkg::*;
#(
    parameter int MAX_EDGE = MAX_EDGE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  item_t                item,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [H2_W-1:0]      cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The register file takes a write in any cycle.
    assign cfg_ready = 1'b1;

    jac3d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .sweep_req (item.action == ACT_SWEEP),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    jac3d_dp #(
        .MAX_EDGE (MAX_EDGE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .item      (item),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule
